// ===== design/sha512_pkg.sv =====
// ============================================================================
// SHA-512 package
// Round constants, initial hash values and helper functions.
// ============================================================================
package sha512_pkg;

    typedef logic [63:0] word_t;

    localparam int unsigned NumRounds = 80;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    // Initial hash value for word i.
    function automatic word_t iv_word(input logic [2:0] i);
        word_t r;
        unique case (i)
            3'd0: r = 64'h6a09e667f3bcc908;
            3'd1: r = 64'hbb67ae8584caa73b;
            3'd2: r = 64'h3c6ef372fe94f82b;
            3'd3: r = 64'ha54ff53a5f1d36f1;
            3'd4: r = 64'h510e527fade682d1;
            3'd5: r = 64'h9b05688c2b3e6c1f;
            3'd6: r = 64'h1f83d9abfb41bd6b;
            3'd7: r = 64'h5be0cd19137e2179;
            default: r = '0;
        endcase
        return r;
    endfunction

    localparam word_t K512 [0:79] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

endpackage

// ===== design/sha512_hash_core.sv =====
// ============================================================================
// SHA-512 hash core
// Streaming SHA-512 with 64-bit big-endian input words and padding.
// ============================================================================
// A non-last item is written into the block buffer when it is accepted. The
// sixteenth word of a block starts the compression, which runs one round per
// cycle for 80 rounds and then folds the result into the hash. A last item
// adds padding words at one per cycle, one or two compressions, and then
// eight digest items, one per accepted output handshake. The input is not
// ready while padding, compressing or delivering the digest, so the words of
// the next block are taken only after the current block is folded in.
module sha512_hash_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [63:0]          data_word,
    input  logic [3:0]           valid_bytes,
    input  logic                 last_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [63:0]          digest_word,
    output logic                 digest_last
);
    import sha512_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PAD, ST_ROUND, ST_FOLD, ST_OUT
    } state_t;

    state_t      state_reg;
    word_t       hash_reg [8];
    word_t       wbuf_reg [16];
    word_t       var_reg  [8];
    logic [3:0]  fill_reg;
    logic [63:0] len_reg;
    logic [6:0]  round_reg;
    logic [2:0]  out_idx_reg;
    logic        final_reg;    // message end seen; padding in progress
    logic        pad80_reg;    // a standalone 0x80 word is still due
    logic        len_slot_reg; // the current block carries the length word
    logic        len_done_reg; // the length word has been written

    // Byte count of a last item, saturated to eight.
    logic [3:0]  nbytes;
    logic [63:0] keep_mask;
    logic [63:0] last_data;
    logic [63:0] len_next;
    assign nbytes = (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
    always_comb
    begin
        keep_mask = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (4'(b) < nbytes)
            begin
                keep_mask[63 - 8*b -: 8] = 8'hff;
            end
        end
    end
    assign last_data = (data_word & keep_mask) |
                       (nbytes == 4'd8 ? 64'd0 : (64'h80 << (7'd56 - {nbytes, 3'b000})));
    assign len_next = len_reg + (last_word ? {57'd0, nbytes, 3'b000} : 64'd64);

    // Word to write during padding.
    logic [63:0] pad_word;
    always_comb
    begin
        priority if (pad80_reg)
            pad_word = 64'h8000000000000000;
        else if (fill_reg == 4'd15 && len_slot_reg)
            pad_word = len_reg;
        else
            pad_word = '0;
    end

    // Message schedule and round logic, one round per cycle.
    logic [3:0]  t_idx;
    word_t       a15, a2, ws0, ws1, w_new, wt, t1, t2, s1e, s0a, ch, mj;
    assign t_idx = round_reg[3:0];
    assign a15   = wbuf_reg[t_idx + 4'd1];
    assign a2    = wbuf_reg[t_idx + 4'd14];
    assign ws0   = rotr(a15, 1) ^ rotr(a15, 8) ^ (a15 >> 7);
    assign ws1   = rotr(a2, 19) ^ rotr(a2, 61) ^ (a2 >> 6);
    assign w_new = wbuf_reg[t_idx] + ws0 + wbuf_reg[t_idx + 4'd9] + ws1;
    assign wt    = (round_reg < 7'd16) ? wbuf_reg[t_idx] : w_new;
    assign s1e   = rotr(var_reg[4], 14) ^ rotr(var_reg[4], 18) ^ rotr(var_reg[4], 41);
    assign ch    = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
    assign t1    = var_reg[7] + s1e + ch + K512[round_reg] + wt;
    assign s0a   = rotr(var_reg[0], 28) ^ rotr(var_reg[0], 34) ^ rotr(var_reg[0], 39);
    assign mj    = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2]) ^
                   (var_reg[1] & var_reg[2]);
    assign t2    = s0a + mj;

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_OUT);
    assign digest_word = hash_reg[out_idx_reg];
    assign digest_last = (out_idx_reg == 3'd7);

    // Control state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            len_reg      <= '0;
            round_reg    <= '0;
            out_idx_reg  <= '0;
            final_reg    <= 1'b0;
            pad80_reg    <= 1'b0;
            len_slot_reg <= 1'b0;
            len_done_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        len_reg  <= len_next;
                        fill_reg <= fill_reg + 4'd1;
                        if (last_word)
                        begin
                            final_reg    <= 1'b1;
                            pad80_reg    <= (nbytes == 4'd8);
                            // The length fits if the 0x80 byte lands in slot 13 or lower.
                            len_slot_reg <= (nbytes == 4'd8) ? (fill_reg <= 4'd12)
                                                             : (fill_reg <= 4'd13);
                            state_reg    <= (fill_reg == 4'd15) ? ST_ROUND : ST_PAD;
                        end
                        else if (fill_reg == 4'd15)
                        begin
                            state_reg <= ST_ROUND;
                        end
                    end
                end
                ST_PAD:
                begin
                    pad80_reg <= 1'b0;
                    fill_reg  <= fill_reg + 4'd1;
                    if (fill_reg == 4'd15)
                    begin
                        if (len_slot_reg)
                            len_done_reg <= 1'b1;
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    round_reg <= round_reg + 7'd1;
                    if (round_reg == 7'(NumRounds - 1))
                        state_reg <= ST_FOLD;
                end
                ST_FOLD:
                begin
                    round_reg <= '0;
                    if (!final_reg)
                        state_reg <= ST_IDLE;
                    else if (len_done_reg)
                        state_reg <= ST_OUT;
                    else
                    begin
                        // A block started during padding always holds the length.
                        len_slot_reg <= 1'b1;
                        state_reg    <= ST_PAD;
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == 3'd7)
                        begin
                            state_reg    <= ST_IDLE;
                            final_reg    <= 1'b0;
                            len_done_reg <= 1'b0;
                            len_reg      <= '0;
                            fill_reg     <= '0;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath storage: block buffer, working variables and hash words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= iv_word(3'(i));
        end
        else
        begin
            if (state_reg == ST_FOLD)
            begin
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= hash_reg[i] + var_reg[i];
            end
            if (state_reg == ST_OUT && out_ready && out_idx_reg == 3'd7)
            begin
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= iv_word(3'(i));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
            wbuf_reg[fill_reg] <= last_word ? last_data : data_word;
        if (state_reg == ST_PAD)
            wbuf_reg[fill_reg] <= pad_word;
        if (state_reg == ST_ROUND && round_reg >= 7'd16)
            wbuf_reg[t_idx] <= w_new;
        if ((state_reg == ST_IDLE && in_valid && fill_reg == 4'd15) ||
            (state_reg == ST_PAD && fill_reg == 4'd15))
        begin
            for (int i = 0; i < 8; i++)
                var_reg[i] <= hash_reg[i];
        end
        else if (state_reg == ST_ROUND)
        begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
    end

endmodule

// ===== design/sha512_checker.sv =====
// ============================================================================
// SHA-512 port checker
// Checks the port behavior of the hash core over time.
// ============================================================================
module sha512_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] digest_word,
    input logic        digest_last
);
    // The core never takes an item while it is delivering a digest.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input ready during digest");

    // A pending digest item holds its data.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest_word))
        else $error("digest item changed while stalled");

    // After the final digest item the core is ready for a new message.
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && digest_last |=> in_ready && !out_valid)
        else $error("core not idle after digest");

    // The digest items follow one another until the final one.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !digest_last |=> out_valid)
        else $error("digest stream broken");
endmodule

bind sha512_hash_core sha512_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .digest_word(digest_word), .digest_last(digest_last)
);
